// File: rtl/jts_pkg.sv
package jts_pkg;

   localparam int MaxDepth = 16;
   localparam int DepthW = 4;

   localparam logic [3:0] CMD_RESET     = 4'd0;
   localparam logic [3:0] CMD_OBJ_OPEN  = 4'd1;
   localparam logic [3:0] CMD_OBJ_CLOSE = 4'd2;
   localparam logic [3:0] CMD_ARR_OPEN  = 4'd3;
   localparam logic [3:0] CMD_ARR_CLOSE = 4'd4;
   localparam logic [3:0] CMD_INT       = 4'd5;
   localparam logic [3:0] CMD_STR_BEGIN = 4'd6;
   localparam logic [3:0] CMD_STR_CHAR  = 4'd7;
   localparam logic [3:0] CMD_STR_END   = 4'd8;
   localparam logic [3:0] CMD_TRUE      = 4'd9;
   localparam logic [3:0] CMD_FALSE     = 4'd10;
   localparam logic [3:0] CMD_NULL      = 4'd11;

   typedef struct packed {
      logic       start;
      logic [63:0] mag;
   } conv_req_type;

   typedef struct packed {
      logic        done;
      logic [4:0]  num_digits;
      logic [79:0] digits;
   } conv_rsp_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'd0, nib};
      end else begin
         r = 8'h57 + {4'd0, nib};
      end
      return r;
   endfunction

endpackage

// File: rtl/jts_dec_conv.sv
module jts_dec_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  jts_pkg::conv_req_type conv_req,
   output jts_pkg::conv_rsp_type conv_rsp
);

   // shift-and-add-3 binary to bcd, one bit per cycle
   logic [63:0] bin_ff, bin_in;
   logic [79:0] bcd_ff, bcd_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [79:0] adj;
   logic [4:0]  nd;

   always_comb begin
      for (int i = 0; i < 20; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
      nd = 5'd1;
      for (int i = 1; i < 20; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            nd = 5'(i + 1);
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (conv_req.start) begin
         bin_in = conv_req.mag;
         bcd_in = '0;
         cnt_in = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[78:0], bin_ff[63]};
         bin_in = {bin_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign conv_rsp.done = done_ff;
   assign conv_rsp.digits = bcd_ff;
   assign conv_rsp.num_digits = nd;

endmodule

// File: rtl/json_token_serializer.sv
// json token serializer
// req channel: one token command per beat; tdata = command[3:0], int_value[67:4],
// text_char[75:68]. rsp channel: one character per beat; tdata = out_char[7:0],
// nest_depth[11:8], level_items[27:12]; tlast marks the final character of a command.
// a command is taken only while the block is idle; it then emits its characters
// one per cycle from an output register while the receiver is ready. an integer
// first runs a bit-serial 64-bit binary to decimal conversion in the converter,
// then streams up to 21 characters. reset and unknown commands emit nothing. a
// stalled receiver holds the current beat and the sequencer waits. synchronous
// reset clears depth to zero, level zero to an empty array level and leaves the
// block idle and ready. level counts and kinds above level zero are written by an
// open before they are read.
module json_token_serializer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // command, int_value, text_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_char, nest_depth, level_items
   output logic        rsp_tlast
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_CONV = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  cmd_ff, cmd_in;
   logic [63:0] ival_ff, ival_in;
   logic [7:0]  tc_ff, tc_in;
   logic [3:0]  depth_ff, depth_in;
   logic [15:0] cnt_mem [jts_pkg::MaxDepth];
   logic        obj_mem [jts_pkg::MaxDepth];
   logic        mem_we;
   logic [3:0]  mem_wa;
   logic [15:0] mem_wc;
   logic        mem_wo;
   logic [7:0]  buf_ff [24];
   logic [7:0]  buf_in [24];
   logic [4:0]  len_ff, len_in;
   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  ch_ff, ch_in;
   logic        last_ff, last_in;
   logic [15:0] items_ff, items_in;
   logic        vld_ff, vld_in;
   jts_pkg::conv_req_type conv_req;
   jts_pkg::conv_rsp_type conv_rsp;
   logic [15:0] cur_cnt;
   logic        cur_obj;
   logic        neg;
   logic [63:0] mag;

   jts_dec_conv u_conv (
      .clock    (clock),
      .reset    (reset),
      .conv_req (conv_req),
      .conv_rsp (conv_rsp)
   );

   assign cur_cnt = cnt_mem[depth_ff];
   assign cur_obj = obj_mem[depth_ff];
   assign neg = ival_ff[63];
   assign mag = neg ? (~ival_ff + 64'd1) : ival_ff;

   always_comb begin
      logic [4:0]  n;
      logic        sep;
      logic [15:0] ncnt;
      logic [3:0]  nd;
      n = '0;
      sep = 1'b0;
      ncnt = '0;
      nd = depth_ff;
      state_in = state_ff;
      cmd_in = cmd_ff;
      ival_in = ival_ff;
      tc_in = tc_ff;
      depth_in = depth_ff;
      buf_in = buf_ff;
      len_in = len_ff;
      pos_in = pos_ff;
      ch_in = ch_ff;
      last_in = last_ff;
      items_in = items_ff;
      vld_in = vld_ff;
      mem_we = 1'b0;
      mem_wa = depth_ff;
      mem_wc = '0;
      mem_wo = 1'b0;
      conv_req.start = 1'b0;
      conv_req.mag = mag;
      req_tready = (state_ff == S_IDLE) && !vld_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = req_tdata[3:0];
               ival_in = req_tdata[67:4];
               tc_in = req_tdata[75:68];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            sep = (cmd_ff == jts_pkg::CMD_OBJ_OPEN) || (cmd_ff == jts_pkg::CMD_ARR_OPEN)
               || (cmd_ff == jts_pkg::CMD_INT) || (cmd_ff == jts_pkg::CMD_STR_BEGIN)
               || (cmd_ff == jts_pkg::CMD_TRUE) || (cmd_ff == jts_pkg::CMD_FALSE)
               || (cmd_ff == jts_pkg::CMD_NULL);
            if (sep && cur_cnt != 16'd0) begin
               buf_in[0] = (cur_obj && cur_cnt[0]) ? 8'h3a : 8'h2c;
               n = 5'd1;
            end
            if (sep) begin
               ncnt = (cur_cnt == 16'hffff) ? cur_cnt : cur_cnt + 16'd1;
               mem_we = 1'b1;
               mem_wc = ncnt;
               mem_wo = cur_obj;
               items_in = ncnt;
            end else begin
               items_in = cur_cnt;
            end
            state_in = S_OUT;
            case (cmd_ff) inside
               jts_pkg::CMD_RESET: begin
                  nd = 4'd0;
                  mem_we = 1'b1;
                  mem_wa = 4'd0;
                  items_in = 16'd0;
                  state_in = S_IDLE;
               end
               jts_pkg::CMD_OBJ_OPEN, jts_pkg::CMD_ARR_OPEN: begin
                  buf_in[n] = (cmd_ff == jts_pkg::CMD_OBJ_OPEN) ? 8'h7b : 8'h5b;
                  n = n + 5'd1;
                  if (depth_ff != 4'(jts_pkg::MaxDepth - 1)) begin
                     nd = depth_ff + 4'd1;
                     items_in = 16'd0;
                  end
               end
               jts_pkg::CMD_OBJ_CLOSE, jts_pkg::CMD_ARR_CLOSE: begin
                  buf_in[0] = (cmd_ff == jts_pkg::CMD_OBJ_CLOSE) ? 8'h7d : 8'h5d;
                  n = 5'd1;
                  if (depth_ff != 4'd0) begin
                     nd = depth_ff - 4'd1;
                     items_in = cnt_mem[depth_ff - 4'd1];
                  end
               end
               jts_pkg::CMD_INT: begin
                  if (neg) begin
                     buf_in[n] = 8'h2d;
                     n = n + 5'd1;
                  end
                  conv_req.start = 1'b1;
                  state_in = S_CONV;
               end
               jts_pkg::CMD_STR_BEGIN, jts_pkg::CMD_STR_END: begin
                  buf_in[n] = 8'h22;
                  n = n + 5'd1;
               end
               jts_pkg::CMD_STR_CHAR: begin
                  if (tc_ff < 8'h20) begin
                     buf_in[0] = 8'h5c;
                     buf_in[1] = 8'h75;
                     buf_in[2] = 8'h30;
                     buf_in[3] = 8'h30;
                     buf_in[4] = jts_pkg::hex_char(tc_ff[7:4]);
                     buf_in[5] = jts_pkg::hex_char(tc_ff[3:0]);
                     n = 5'd6;
                  end else if (tc_ff == 8'h5c || tc_ff == 8'h22) begin
                     buf_in[0] = 8'h5c;
                     buf_in[1] = tc_ff;
                     n = 5'd2;
                  end else begin
                     buf_in[0] = tc_ff;
                     n = 5'd1;
                  end
               end
               jts_pkg::CMD_TRUE: begin
                  buf_in[n] = 8'h74; buf_in[n+5'd1] = 8'h72;
                  buf_in[n+5'd2] = 8'h75; buf_in[n+5'd3] = 8'h65;
                  n = n + 5'd4;
               end
               jts_pkg::CMD_FALSE: begin
                  buf_in[n] = 8'h66; buf_in[n+5'd1] = 8'h61;
                  buf_in[n+5'd2] = 8'h6c; buf_in[n+5'd3] = 8'h73;
                  buf_in[n+5'd4] = 8'h65;
                  n = n + 5'd5;
               end
               jts_pkg::CMD_NULL: begin
                  buf_in[n] = 8'h6e; buf_in[n+5'd1] = 8'h75;
                  buf_in[n+5'd2] = 8'h6c; buf_in[n+5'd3] = 8'h6c;
                  n = n + 5'd4;
               end
               default: begin
                  nd = depth_ff;
                  state_in = S_IDLE;
               end
            endcase
            depth_in = nd;
            len_in = n;
            pos_in = 5'd0;
         end
         S_CONV: begin
            if (conv_rsp.done) begin
               pos_in = 5'(conv_rsp.num_digits - 5'd1);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            buf_in[len_ff] = {4'h3, conv_rsp.digits[pos_ff*4 +: 4]};
            len_in = len_ff + 5'd1;
            pos_in = pos_ff - 5'd1;
            if (pos_ff == 5'd0) begin
               pos_in = 5'd0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!vld_ff || rsp_tready) begin
               if (pos_ff == len_ff) begin
                  vld_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  vld_in = 1'b1;
                  ch_in = buf_ff[pos_ff];
                  last_in = (pos_ff + 5'd1 == len_ff);
                  pos_in = pos_ff + 5'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_OUT && vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end
      if (state_ff == S_PREP && (cmd_ff == jts_pkg::CMD_OBJ_OPEN
            || cmd_ff == jts_pkg::CMD_ARR_OPEN) && nd != depth_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= 4'd0;
         vld_ff <= 1'b0;
         cnt_mem[0] <= 16'd0;
         obj_mem[0] <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         vld_ff <= vld_in;
         if (mem_we) begin
            if (state_ff == S_PREP && (cmd_ff == jts_pkg::CMD_OBJ_OPEN
                  || cmd_ff == jts_pkg::CMD_ARR_OPEN) && depth_in != depth_ff) begin
               cnt_mem[depth_ff] <= mem_wc;
               cnt_mem[depth_in] <= 16'd0;
               obj_mem[depth_in] <= (cmd_ff == jts_pkg::CMD_OBJ_OPEN);
            end else begin
               cnt_mem[mem_wa] <= mem_wc;
               obj_mem[mem_wa] <= mem_wo;
            end
         end
      end
      cmd_ff <= cmd_in;
      ival_ff <= ival_in;
      tc_ff <= tc_in;
      buf_ff <= buf_in;
      len_ff <= len_in;
      pos_ff <= pos_in;
      ch_ff <= ch_in;
      last_ff <= last_in;
      items_ff <= items_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = {4'd0, items_ff, depth_ff, ch_ff};

endmodule
